### design/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg: pooled linked list manager package
// Transaction types, operation and status codes, default pool size.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int POOL_NODES_DEF = 32;
    localparam int VALUE_W        = 16;
    localparam int NODE_W         = 5;

    localparam logic [VALUE_W-1:0] VALUE_RESET = '1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NO_SUCC = 2'd3;

    typedef struct packed {
        logic [1:0]                opcode;
        logic                      at_head;
        logic [NODE_W-1:0]         pred_index;
        logic signed [VALUE_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [NODE_W-1:0]         node_index;
        logic                      head_valid;
        logic [NODE_W-1:0]         head_index;
        logic signed [VALUE_W-1:0] read_value;
        logic                      read_next_valid;
        logic [NODE_W-1:0]         read_next;
    } rsp_t;

endpackage

### design/plm_ram.sv
// ----------------------------------------------------------------------------
// plm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module plm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/plm_ctrl.sv
// ----------------------------------------------------------------------------
// plm_ctrl: list sequencer
// Holds list and free heads, runs read-modify-write sequences on the node
// value and link memories, and clears them after reset.
// ----------------------------------------------------------------------------
module plm_ctrl
    import plm_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF,
    localparam int IW = $clog2(POOL_NODES),
    localparam int LW = IW + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               res_valid,
    input  logic               res_ready,
    output rsp_t               res,
    output logic               link_we,
    output logic [IW-1:0]      link_waddr,
    output logic [LW-1:0]      link_wdata,
    output logic               val_we,
    output logic [IW-1:0]      val_waddr,
    output logic [VALUE_W-1:0] val_wdata,
    output logic               rd_en,
    output logic [IW-1:0]      rd_addr,
    input  logic [LW-1:0]      link_rdata,
    input  logic [VALUE_W-1:0] val_rdata
);

    localparam logic [LW-1:0] LINK_END = LW'(POOL_NODES);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_LINK   = 6'b001000,
        S_WRITE  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       list_head_reg, list_head_next;
    logic [LW-1:0]       free_head_reg, free_head_next;
    logic [IW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [1:0]          op_reg, op_next;
    logic                at_head_reg, at_head_next;
    logic [IW-1:0]       pred_reg, pred_next;
    logic [VALUE_W-1:0]  item_reg, item_next;
    logic [IW-1:0]       t_reg, t_next;
    logic [1:0]          status_reg, status_next;
    logic [IW-1:0]       node_reg, node_next;
    logic [VALUE_W-1:0]  rval_reg, rval_next;
    logic                rnv_reg, rnv_next;
    logic [IW-1:0]       rnext_reg, rnext_next;
    logic [NODE_W-1:0]   pred_mod;
    logic [IW-1:0]       pred_w;
    logic                head_ok;

    // predecessor wraps modulo the pool size
    always_comb
    begin
        pred_mod = req.pred_index;
        for (int k = NODE_W - 1; k >= 0; k--)
        begin
            if (int'(pred_mod) >= (POOL_NODES << k))
            begin
                pred_mod = pred_mod - NODE_W'(POOL_NODES << k);
            end
        end
        pred_w = IW'(pred_mod);
    end

    assign head_ok = list_head_reg < LINK_END;

    always_comb
    begin
        state_next     = state_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        at_head_next   = at_head_reg;
        pred_next      = pred_reg;
        item_next      = item_reg;
        t_next         = t_reg;
        status_next    = status_reg;
        node_next      = node_reg;
        rval_next      = rval_reg;
        rnv_next       = rnv_reg;
        rnext_next     = rnext_reg;
        link_we        = 1'b0;
        link_waddr     = t_reg;
        link_wdata     = free_head_reg;
        val_we         = 1'b0;
        val_waddr      = t_reg;
        val_wdata      = item_reg;
        rd_en          = 1'b0;
        rd_addr        = pred_w;
        req_ready      = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                link_we      = 1'b1;
                link_waddr   = clr_cnt_reg;
                link_wdata   = LW'(clr_cnt_reg) + LW'(1);
                val_we       = 1'b1;
                val_waddr    = clr_cnt_reg;
                val_wdata    = VALUE_RESET;
                clr_cnt_next = clr_cnt_reg + IW'(1);
                if (clr_cnt_reg == IW'(POOL_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next      = req.opcode;
                    at_head_next = req.at_head;
                    pred_next    = pred_w;
                    item_next    = req.item_value;
                    status_next  = ST_OK;
                    node_next    = '0;
                    rval_next    = '0;
                    rnv_next     = 1'b0;
                    rnext_next   = '0;
                    unique case (req.opcode)
                        OP_INSERT:
                        begin
                            if (free_head_reg < LINK_END)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = free_head_reg[IW-1:0];
                                t_next     = free_head_reg[IW-1:0];
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESULT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!head_ok)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = req.at_head ? list_head_reg[IW-1:0] : pred_w;
                                t_next     = list_head_reg[IW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        OP_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        free_head_next = link_rdata;
                        node_next      = t_reg;
                        val_we         = 1'b1;
                        if (at_head_reg)
                        begin
                            link_we        = 1'b1;
                            link_wdata     = list_head_reg;
                            list_head_next = LW'(t_reg);
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pred_reg;
                            state_next = S_LINK;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (at_head_reg)
                        begin
                            list_head_next = link_rdata;
                            link_we        = 1'b1;
                            val_we         = 1'b1;
                            val_wdata      = VALUE_RESET;
                            free_head_next = LW'(t_reg);
                            node_next      = t_reg;
                            state_next     = S_RESULT;
                        end
                        else if (link_rdata >= LINK_END)
                        begin
                            status_next = ST_NO_SUCC;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            t_next     = link_rdata[IW-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = link_rdata[IW-1:0];
                            state_next = S_LINK;
                        end
                    end
                    OP_READ:
                    begin
                        node_next = pred_reg;
                        rval_next = val_rdata;
                        if (link_rdata < LINK_END)
                        begin
                            rnv_next   = 1'b1;
                            rnext_next = link_rdata[IW-1:0];
                        end
                        state_next = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_LINK:
            begin
                link_we    = 1'b1;
                link_wdata = link_rdata;
                if (op_reg != OP_INSERT)
                begin
                    link_waddr = pred_reg;
                end
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                link_we = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    link_waddr = pred_reg;
                    link_wdata = LW'(t_reg);
                end
                else
                begin
                    val_we         = 1'b1;
                    val_wdata      = VALUE_RESET;
                    free_head_next = LW'(t_reg);
                    node_next      = t_reg;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status          = status_reg;
        res.node_index      = NODE_W'(node_reg);
        res.head_valid      = head_ok;
        res.head_index      = head_ok ? NODE_W'(list_head_reg) : '0;
        res.read_value      = rval_reg;
        res.read_next_valid = rnv_reg;
        res.read_next       = NODE_W'(rnext_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            list_head_reg <= LINK_END;
            free_head_reg <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        at_head_reg <= at_head_next;
        pred_reg    <= pred_next;
        item_reg    <= item_next;
        t_reg       <= t_next;
        status_reg  <= status_next;
        node_reg    <= node_next;
        rval_reg    <= rval_next;
        rnv_reg     <= rnv_next;
        rnext_reg   <= rnext_next;
    end

endmodule

### design/pooled_linked_list_manager_top.sv
// ----------------------------------------------------------------------------
// pooled_linked_list_manager_top: pooled singly linked list with free list
// Node values and links live in two RAMs; a sequencer walks them per
// transaction and a response register decouples the output side.
//
//   channel | signals                    | transaction
//   req     | req_valid, req_ready, req  | one operation (insert/delete/read)
//   rsp     | rsp_valid, rsp_ready, rsp  | one result per operation
//
// An operation keeps req_ready low until its result enters the response
// register. Full/empty/unused go straight to the result state; read, head
// insert/delete or missing successor pass through fetch; insert or delete
// after a node through fetch, link and write, set by the chain of dependent
// link RAM reads and the single link RAM write port. A clearing pass after
// reset initialises both RAMs, with req_ready low. A stalled rsp holds the
// sequencer in its result state while the response register is full.
// ----------------------------------------------------------------------------
module pooled_linked_list_manager_top
    import plm_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IW = $clog2(POOL_NODES);
    localparam int LW = IW + 1;

    logic               res_valid;
    logic               res_ready;
    rsp_t               res;
    logic               link_we;
    logic [IW-1:0]      link_waddr;
    logic [LW-1:0]      link_wdata;
    logic               val_we;
    logic [IW-1:0]      val_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [LW-1:0]      link_rdata;
    logic [VALUE_W-1:0] val_rdata;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    plm_ctrl #(
        .POOL_NODES (POOL_NODES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .val_we     (val_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .link_rdata (link_rdata),
        .val_rdata  (val_rdata)
    );

    plm_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    plm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POOL_NODES)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### design/plm_checker.sv
// ----------------------------------------------------------------------------
// plm_checker: port-level checks for the list manager
// Response hold, busy after acceptance, status against head state.
// ----------------------------------------------------------------------------
module plm_checker
    import plm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transaction taken straight after acceptance");

    a_empty_has_no_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> !rsp.head_valid)
        else $error("empty status with a list head");

    a_no_succ_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_NO_SUCC |-> rsp.head_valid)
        else $error("missing successor reported on an empty list");

endmodule

bind pooled_linked_list_manager_top plm_checker u_plm_checker (.*);

### bench/tb_pooled_linked_list_manager_top.sv
// ----------------------------------------------------------------------------
// tb_pooled_linked_list_manager_top: regression for the pooled linked list
// Runs a directed sequence and then random operations through the block. A
// scoreboard mirrors the node pool, the list and the free list. It predicts
// one response per accepted request and checks every field of it in order.
// ----------------------------------------------------------------------------
import plm_pkg::*;

class list_scoreboard;

    localparam int NODES = POOL_NODES_DEF;

    logic signed [VALUE_W-1:0] node_val [NODES];
    logic [NODE_W:0]           node_next [NODES];
    logic [NODE_W:0]           list_first;
    logic [NODE_W:0]           free_first;
    rsp_t                      awaited[$];
    int                        errors;
    int                        op_count [4];
    int                        status_count [4];

    function new();
        for (int i = 0; i < NODES; i++)
        begin
            node_val[i]  = VALUE_RESET;
            node_next[i] = (NODE_W+1)'(i + 1);
        end
        list_first = (NODE_W+1)'(NODES);
        free_first = '0;
        errors     = 0;
        op_count     = '{default: 0};
        status_count = '{default: 0};
    endfunction

    function bit is_node(logic [NODE_W:0] link);
        return link < NODES;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void note_request(req_t r);
        rsp_t              e;
        logic [NODE_W-1:0] t;
        logic [NODE_W-1:0] p;
        e = '0;
        p = NODE_W'(int'(r.pred_index) % NODES);
        case (r.opcode)
            OP_INSERT:
            begin
                if (!is_node(free_first))
                    e.status = ST_FULL;
                else
                begin
                    t          = free_first[NODE_W-1:0];
                    free_first = node_next[t];
                    node_val[t] = r.item_value;
                    if (r.at_head)
                    begin
                        node_next[t] = list_first;
                        list_first   = {1'b0, t};
                    end
                    else
                    begin
                        node_next[t] = node_next[p];
                        node_next[p] = {1'b0, t};
                    end
                    e.node_index = t;
                end
            end
            OP_DELETE:
            begin
                if (!is_node(list_first))
                    e.status = ST_EMPTY;
                else if (!r.at_head && !is_node(node_next[p]))
                    e.status = ST_NO_SUCC;
                else
                begin
                    if (r.at_head)
                    begin
                        t          = list_first[NODE_W-1:0];
                        list_first = node_next[t];
                    end
                    else
                    begin
                        t            = node_next[p][NODE_W-1:0];
                        node_next[p] = node_next[t];
                    end
                    node_next[t] = free_first;
                    node_val[t]  = VALUE_RESET;
                    free_first   = {1'b0, t};
                    e.node_index = t;
                end
            end
            OP_READ:
            begin
                e.node_index = p;
                e.read_value = node_val[p];
                if (is_node(node_next[p]))
                begin
                    e.read_next_valid = 1'b1;
                    e.read_next       = node_next[p][NODE_W-1:0];
                end
            end
            default: ;
        endcase
        e.head_valid = is_node(list_first);
        e.head_index = is_node(list_first) ? list_first[NODE_W-1:0] : '0;
        op_count[r.opcode]++;
        status_count[e.status]++;
        awaited.push_back(e);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_response(rsp_t got);
        rsp_t want;
        if (awaited.size() == 0)
        begin
            $display("%0t: unexpected response, expected none, got %p", $time, got);
            errors++;
            return;
        end
        want = awaited.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("node_index", 32'(want.node_index), 32'(got.node_index));
        compare_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
        compare_field("head_index", 32'(want.head_index), 32'(got.head_index));
        compare_field("read_value", 32'(want.read_value), 32'(got.read_value));
        compare_field("read_next_valid", 32'(want.read_next_valid),
                      32'(got.read_next_valid));
        compare_field("read_next", 32'(want.read_next), 32'(got.read_next));
    endfunction

endclass

module tb_pooled_linked_list_manager_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 2_000_000;

    typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} mix_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int req_idle_pct;
    int rsp_stall_pct;
    bit hold_rsp;

    list_scoreboard sb = new();

    pooled_linked_list_manager_top #(
        .POOL_NODES (POOL_NODES_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("pooled_linked_list_manager_top regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    // response side: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                hold_left = HOLD_CYCLES;
                hold_rsp  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    function automatic req_t mk(logic [1:0] opcode, logic at_head, int pred, int value);
        req_t r;
        r.opcode     = opcode;
        r.at_head    = at_head;
        r.pred_index = pred[NODE_W-1:0];
        r.item_value = value[VALUE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly operations on nodes that are on the list, some noise
    function automatic req_t make_req(mix_t mode);
        req_t              r;
        logic [NODE_W:0]   cur;
        logic [NODE_W-1:0] on_list[$];
        logic [NODE_W-1:0] with_succ[$];
        int                roll;
        int                ins_w;
        int                del_w;
        cur = sb.list_first;
        for (int k = 0; k < POOL_NODES_DEF && sb.is_node(cur); k++)
        begin
            on_list.push_back(cur[NODE_W-1:0]);
            if (sb.is_node(sb.node_next[cur[NODE_W-1:0]]))
                with_succ.push_back(cur[NODE_W-1:0]);
            cur = sb.node_next[cur[NODE_W-1:0]];
        end
        r.item_value = pick_value();
        r.pred_index = NODE_W'($urandom_range(POOL_NODES_DEF - 1));
        r.at_head    = 1'($urandom_range(1));
        r.opcode     = 2'($urandom_range(3));
        if ($urandom_range(99) < 10)
            return r;
        case (mode)
            FILL_UP:    begin ins_w = 75; del_w = 10; end
            DRAIN_DOWN: begin ins_w = 15; del_w = 70; end
            default:    begin ins_w = 40; del_w = 35; end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_w)
        begin
            r.opcode = OP_INSERT;
            if (!r.at_head && on_list.size() > 0)
                r.pred_index = on_list[$urandom_range(on_list.size() - 1)];
        end
        else if (roll < ins_w + del_w)
        begin
            r.opcode = OP_DELETE;
            if (!r.at_head && with_succ.size() > 0)
                r.pred_index = with_succ[$urandom_range(with_succ.size() - 1)];
        end
        else
        begin
            r.opcode = OP_READ;
            if (on_list.size() > 0 && $urandom_range(1))
                r.pred_index = on_list[$urandom_range(on_list.size() - 1)];
        end
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic send_req(input req_t r);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        req_t directed[$];
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        hold_rsp      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed = '{
            mk(OP_READ,   1'b0,  0, 0),
            mk(OP_READ,   1'b0, 31, 0),
            mk(OP_DELETE, 1'b1,  0, 0),          // empty list
            mk(OP_DELETE, 1'b0, 31, 0),
            mk(OP_INSERT, 1'b1,  0, 32767),
            mk(OP_INSERT, 1'b1, 31, -32768),
            mk(OP_INSERT, 1'b0,  0, 0),
            mk(OP_INSERT, 1'b0,  2, -1),
            mk(OP_READ,   1'b1,  1, 0),
            mk(OP_READ,   1'b0,  3, 0),
            mk(OP_DELETE, 1'b0,  3, 0),          // no successor
            mk(OP_DELETE, 1'b0,  0, 0),
            mk(OP_READ,   1'b0,  2, 0),          // freed node
            mk(OP_UNUSED, 1'b1, 31, -1),
            mk(OP_DELETE, 1'b1,  0, 0),
            mk(OP_INSERT, 1'b0, 31, 21845),      // after a free node
            mk(OP_DELETE, 1'b0,  0, 0),
            mk(OP_DELETE, 1'b1,  0, 0),
            mk(OP_INSERT, 1'b0,  7, -21846),     // after a node, list empty
            mk(OP_READ,   1'b0,  0, 0),
            mk(OP_READ,   1'b0,  7, 0)
        };
        foreach (directed[i])
            send_req(directed[i]);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / 220) % 4)
                0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin req_idle_pct = 66; rsp_stall_pct = 0;  end
                2: begin req_idle_pct = 0;  rsp_stall_pct = 66; end
                default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
            endcase
            if (n == 600)
                hold_rsp = 1'b1;
            if (n == 1200)
                drain();
            send_req(make_req(mix_t'((n / 90) % 3)));
        end
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d transactions: %0d insert, %0d delete, %0d read, %0d unused opcode",
                 sb.op_count.sum(), sb.op_count[OP_INSERT], sb.op_count[OP_DELETE],
                 sb.op_count[OP_READ], sb.op_count[OP_UNUSED]);
        $display("outcomes: %0d ok, %0d pool full, %0d list empty, %0d no successor",
                 sb.status_count[ST_OK], sb.status_count[ST_FULL],
                 sb.status_count[ST_EMPTY], sb.status_count[ST_NO_SUCC]);
        if (sb.errors == 0)
            $display("pooled_linked_list_manager_top regression: pass");
        else
            $display("pooled_linked_list_manager_top regression: fail");
        $finish;
    end

endmodule
